### sv/ifr_pkg.sv
`default_nettype none

package ifr_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int FRAC_BITS = 16;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
  localparam int KEY_D  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int KA_W   = $clog2(KEY_D);
  localparam int KEY_W  = $clog2(KEY_D + 1);

  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int DCNT_W   = $clog2(PROD_W);
  localparam int CFG_W    = 16;
  localparam int CIDX_W   = 2;
  localparam int DIM_IN_W = 7;

  localparam logic [CFG_W-1:0] THR_RESET =
    CFG_W'((((1 << FRAC_BITS) + 500) / 1000) & 16'hFFFF);

  typedef enum logic [CIDX_W-1:0] {
    CFG_NUM_ROWS = 2'd0,
    CFG_NUM_COLS = 2'd1,
    CFG_ZERO_THR = 2'd2
  } cfg_idx_t;

  typedef enum logic [5:0] {
    ST_LOAD, ST_CK_RD, ST_CK_CHK, ST_CS_RD, ST_CS_CHK,
    ST_RK_RDC, ST_RK_RDS, ST_RK_CHK, ST_RS_RD, ST_RS_CHK,
    ST_BD_RD, ST_BD_RDS, ST_BD_WR,
    ST_PZ_RD, ST_PZ_CHK, ST_PP_RD, ST_PP_CHK,
    ST_SW_RDA, ST_SW_RDB, ST_SW_WA, ST_SW_WB,
    ST_RO_RDA, ST_RO_RDB, ST_RO_WA, ST_RO_WB,
    ST_PIV_RD, ST_PIV_CHK, ST_EL_J, ST_EF_CHK,
    ST_EK_RDA, ST_EK_RDB, ST_EK_MUL, ST_EK_DST, ST_EK_DIV, ST_EK_WR,
    ST_OZ_RD, ST_OZ_CHK, ST_OR_RD, ST_OR_CHK, ST_OUT_END, ST_ERR
  } state_t;

  function automatic logic [ADDR_W-1:0] mat_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
  endfunction

  function automatic logic [DATA_W-1:0] abs32(logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic is_nz(logic [DATA_W-1:0] x, logic [CFG_W-1:0] thr);
    return abs32(x) > DATA_W'(thr);
  endfunction

  function automatic logic [RCNT_W-1:0] clamp_rows(logic [DIM_IN_W-1:0] v);
    if (v == '0) return RCNT_W'(1);
    if (int'(v) > MAX_ROWS) return RCNT_W'(MAX_ROWS);
    return RCNT_W'(v);
  endfunction

  function automatic logic [CCNT_W-1:0] clamp_cols(logic [DIM_IN_W-1:0] v);
    if (v == '0) return CCNT_W'(1);
    if (int'(v) > MAX_COLS) return CCNT_W'(MAX_COLS);
    return CCNT_W'(v);
  endfunction

endpackage

`default_nettype wire

### sv/ifr_ram.sv
`default_nettype none

module ifr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/independent_row_finder_core.sv
`default_nettype none
// Independent row finder.
// Load: drive in_element with start; an item is taken on each clock edge with
// start high and busy low, one per cycle, row-major, num_rows*num_cols items.
// The last item launches processing and busy stays high until the final
// result. Processing: column keys and stable sort, row keys and stable sort,
// copy into the work store, then Gauss-Jordan elimination. Each element update
// uses one shared 32x32 multiplier and one bit-serial divider (64 steps); the
// divider is skipped when the product is zero.
// Results: out_valid strobes for one cycle per independent row, original row
// index in order, out_is_last on the final one. No survivors gives a single
// out_empty_set result; a nonzero row without a pivot column or a zero pivot
// gives a single out_sanity_error result. The receiver cannot stall: results
// are dropped if not taken in their cycle.
// Config: cfg_we/cfg_index/cfg_data while busy is low; a write to a known
// register also discards a partly loaded matrix.
// Reset: 64 rows, 64 columns, threshold 66, load count zero; the stores are
// not cleared.
module independent_row_finder_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic signed [31:0]         in_element,
  input  wire logic                       cfg_we,
  input  wire logic [ifr_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [ifr_pkg::CFG_W-1:0]  cfg_data,
  output      logic                       out_valid,
  output      logic [5:0]                 out_row_index,
  output      logic                       out_is_last,
  output      logic                       out_empty_set,
  output      logic                       out_sanity_error
);

  import ifr_pkg::*;

  state_t state_r, state_nxt;

  logic [RCNT_W-1:0] num_rows_r, num_rows_nxt;
  logic [CCNT_W-1:0] num_cols_r, num_cols_nxt;
  logic [CFG_W-1:0]  thr_r, thr_nxt;
  logic [ROW_W-1:0]  lr_r, lr_nxt;
  logic [COL_W-1:0]  lc_r, lc_nxt;
  logic [RCNT_W-1:0] i_r, i_nxt, j_r, j_nxt, p_r, p_nxt;
  logic [CCNT_W-1:0] k_r, k_nxt;
  logic [KEY_W-1:0]  v_r, v_nxt, cnt_r, cnt_nxt;
  logic              have_pend_r, have_pend_nxt;
  logic              ov_r, ov_nxt;

  logic [DATA_W-1:0]        tmp_r, tmp_nxt;
  logic signed [DATA_W-1:0] f_r, f_nxt, a_r, a_nxt, w_r, w_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0]        quo_r, quo_nxt;
  logic [DATA_W-1:0]        rem_r, rem_nxt, den_r, den_nxt;
  logic [DCNT_W-1:0]        dcnt_r, dcnt_nxt;
  logic                     piv_neg_r, piv_neg_nxt, qneg_r, qneg_nxt;
  logic [ROW_W-1:0]         pend_r, pend_nxt;
  logic [5:0]               oi_r, oi_nxt;
  logic                     ol_r, ol_nxt, oe_r, oe_nxt, os_r, os_nxt;

  logic              st_we, wk_we, ky_we, co_we, ro_we;
  logic [ADDR_W-1:0] st_waddr, st_raddr, wk_waddr, wk_raddr;
  logic [DATA_W-1:0] st_wdata, st_rdata, wk_wdata, wk_rdata;
  logic [KA_W-1:0]   ky_waddr, ky_raddr;
  logic [KEY_W-1:0]  ky_wdata, ky_rdata;
  logic [COL_W-1:0]  co_waddr, co_raddr, co_wdata, co_rdata;
  logic [ROW_W-1:0]  ro_waddr, ro_raddr, ro_wdata, ro_rdata;

  logic i_last, j_last, p_last, k_last, step_done;
  logic [DATA_W:0]          rem_sh;
  logic signed [PROD_W-1:0] qs;
  logic [PROD_W:0]          d65;
  logic [DATA_W-1:0]        dsat;

  ifr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_store (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(st_raddr), .rdata(st_rdata));
  ifr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_work (
    .clk, .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata), .raddr(wk_raddr), .rdata(wk_rdata));
  ifr_ram #(.WIDTH(KEY_W), .DEPTH(KEY_D)) u_key (
    .clk, .we(ky_we), .waddr(ky_waddr), .wdata(ky_wdata), .raddr(ky_raddr), .rdata(ky_rdata));
  ifr_ram #(.WIDTH(COL_W), .DEPTH(MAX_COLS)) u_corder (
    .clk, .we(co_we), .waddr(co_waddr), .wdata(co_wdata), .raddr(co_raddr), .rdata(co_rdata));
  ifr_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_rorigin (
    .clk, .we(ro_we), .waddr(ro_waddr), .wdata(ro_wdata), .raddr(ro_raddr), .rdata(ro_rdata));

  assign i_last = (i_r == num_rows_r - 1'b1);
  assign j_last = (j_r == num_rows_r - 1'b1);
  assign p_last = (p_r == num_rows_r - 1'b1);
  assign k_last = (k_r == num_cols_r - 1'b1);

  // divider step and update datapath
  assign rem_sh = {rem_r, quo_r[PROD_W-1]};
  assign qs     = qneg_r ? -$signed(quo_r) : $signed(quo_r);
  assign d65    = {{(PROD_W - DATA_W + 1){w_r[DATA_W-1]}}, w_r} - {qs[PROD_W-1], qs};
  always_comb begin
    if (d65[PROD_W:DATA_W-1] == '0 || d65[PROD_W:DATA_W-1] == '1) begin
      dsat = d65[DATA_W-1:0];
    end else if (d65[PROD_W]) begin
      dsat = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      dsat = {1'b0, {(DATA_W - 1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    num_rows_nxt  = num_rows_r;
    num_cols_nxt  = num_cols_r;
    thr_nxt       = thr_r;
    lr_nxt        = lr_r;
    lc_nxt        = lc_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    k_nxt         = k_r;
    v_nxt         = v_r;
    cnt_nxt       = cnt_r;
    have_pend_nxt = have_pend_r;
    ov_nxt        = 1'b0;
    tmp_nxt       = tmp_r;
    f_nxt         = f_r;
    a_nxt         = a_r;
    w_nxt         = w_r;
    prod_nxt      = prod_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    dcnt_nxt      = dcnt_r;
    piv_neg_nxt   = piv_neg_r;
    qneg_nxt      = qneg_r;
    pend_nxt      = pend_r;
    oi_nxt        = oi_r;
    ol_nxt        = ol_r;
    oe_nxt        = oe_r;
    os_nxt        = os_r;
    step_done     = 1'b0;
    st_we = 1'b0; st_waddr = '0; st_wdata = in_element; st_raddr = '0;
    wk_we = 1'b0; wk_waddr = '0; wk_wdata = '0;         wk_raddr = '0;
    ky_we = 1'b0; ky_waddr = '0; ky_wdata = '0;         ky_raddr = '0;
    co_we = 1'b0; co_waddr = '0; co_wdata = '0;         co_raddr = '0;
    ro_we = 1'b0; ro_waddr = '0; ro_wdata = '0;         ro_raddr = '0;

    case (state_r)
      ST_LOAD: begin
        if (start) begin
          st_we    = 1'b1;
          st_waddr = mat_addr(lr_r, lc_r);
          if (lc_r == COL_W'(num_cols_r - 1'b1)) begin
            lc_nxt = '0;
            if (lr_r == ROW_W'(num_rows_r - 1'b1)) begin
              lr_nxt    = '0;
              i_nxt     = '0;
              k_nxt     = '0;
              state_nxt = ST_CK_RD;
            end else begin
              lr_nxt = lr_r + 1'b1;
            end
          end else begin
            lc_nxt = lc_r + 1'b1;
          end
        end
        if (cfg_we) begin
          case (cfg_index)
            CFG_NUM_ROWS: begin
              num_rows_nxt = clamp_rows(cfg_data[DIM_IN_W-1:0]);
              lr_nxt = '0; lc_nxt = '0;
            end
            CFG_NUM_COLS: begin
              num_cols_nxt = clamp_cols(cfg_data[DIM_IN_W-1:0]);
              lr_nxt = '0; lc_nxt = '0;
            end
            CFG_ZERO_THR: begin
              thr_nxt = cfg_data;
              lr_nxt = '0; lc_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_CK_RD: begin
        st_raddr  = mat_addr(ROW_W'(i_r), COL_W'(k_r));
        state_nxt = ST_CK_CHK;
      end
      ST_CK_CHK: begin
        if (is_nz(st_rdata, thr_r) || i_last) begin
          ky_we    = 1'b1;
          ky_waddr = KA_W'(k_r);
          ky_wdata = is_nz(st_rdata, thr_r) ? KEY_W'(i_r) + KEY_W'(1) : '0;
          i_nxt    = '0;
          if (k_last) begin
            k_nxt   = '0;
            v_nxt   = KEY_W'(num_rows_r);
            cnt_nxt = '0;
            state_nxt = ST_CS_RD;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = ST_CK_RD;
          end
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = ST_CK_RD;
        end
      end
      ST_CS_RD: begin
        ky_raddr  = KA_W'(k_r);
        state_nxt = ST_CS_CHK;
      end
      ST_CS_CHK: begin
        if (ky_rdata == v_r) begin
          co_we    = 1'b1;
          co_waddr = COL_W'(cnt_r);
          co_wdata = COL_W'(k_r);
          cnt_nxt  = cnt_r + 1'b1;
        end
        state_nxt = ST_CS_RD;
        if (k_last) begin
          k_nxt = '0;
          if (v_r == '0) begin
            i_nxt = '0;
            state_nxt = ST_RK_RDC;
          end else begin
            v_nxt = v_r - 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_RK_RDC: begin
        co_raddr  = COL_W'(k_r);
        state_nxt = ST_RK_RDS;
      end
      ST_RK_RDS: begin
        st_raddr  = mat_addr(ROW_W'(i_r), co_rdata);
        state_nxt = ST_RK_CHK;
      end
      ST_RK_CHK: begin
        state_nxt = ST_RK_RDC;
        if (is_nz(st_rdata, thr_r) || k_last) begin
          ky_we    = 1'b1;
          ky_waddr = KA_W'(i_r);
          ky_wdata = is_nz(st_rdata, thr_r) ? KEY_W'(k_r) + KEY_W'(1) : '0;
          k_nxt    = '0;
          if (i_last) begin
            i_nxt   = '0;
            v_nxt   = '0;
            cnt_nxt = '0;
            state_nxt = ST_RS_RD;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_RS_RD: begin
        ky_raddr  = KA_W'(i_r);
        state_nxt = ST_RS_CHK;
      end
      ST_RS_CHK: begin
        if (ky_rdata == v_r) begin
          ro_we    = 1'b1;
          ro_waddr = ROW_W'(cnt_r);
          ro_wdata = ROW_W'(i_r);
          cnt_nxt  = cnt_r + 1'b1;
        end
        state_nxt = ST_RS_RD;
        if (i_last) begin
          i_nxt = '0;
          if (v_r == KEY_W'(num_cols_r)) begin
            k_nxt = '0;
            state_nxt = ST_BD_RD;
          end else begin
            v_nxt = v_r + 1'b1;
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_BD_RD: begin
        ro_raddr  = ROW_W'(i_r);
        co_raddr  = COL_W'(k_r);
        state_nxt = ST_BD_RDS;
      end
      ST_BD_RDS: begin
        st_raddr  = mat_addr(ro_rdata, co_rdata);
        state_nxt = ST_BD_WR;
      end
      ST_BD_WR: begin
        wk_we     = 1'b1;
        wk_waddr  = mat_addr(ROW_W'(i_r), COL_W'(k_r));
        wk_wdata  = st_rdata;
        state_nxt = ST_BD_RD;
        if (k_last) begin
          k_nxt = '0;
          if (i_last) begin
            i_nxt = '0;
            p_nxt = '0;
            state_nxt = ST_PZ_RD;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_PZ_RD: begin
        wk_raddr  = mat_addr(ROW_W'(p_r), COL_W'(k_r));
        state_nxt = ST_PZ_CHK;
      end
      ST_PZ_CHK: begin
        state_nxt = ST_PZ_RD;
        if (is_nz(wk_rdata, thr_r)) begin
          state_nxt = (i_r < num_cols_r) ? ST_PP_RD : ST_ERR;
        end else if (k_last) begin
          k_nxt = '0;
          if (p_last) begin
            step_done = 1'b1;
          end else begin
            p_nxt = p_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_PP_RD: begin
        wk_raddr  = mat_addr(ROW_W'(p_r), COL_W'(i_r));
        state_nxt = ST_PP_CHK;
      end
      ST_PP_CHK: begin
        k_nxt = '0;
        if (abs32(wk_rdata) < DATA_W'(thr_r)) begin
          if (p_last) begin
            step_done = 1'b1;
          end else begin
            p_nxt = p_r + 1'b1;
            state_nxt = ST_PZ_RD;
          end
        end else begin
          state_nxt = (p_r == i_r) ? ST_PIV_RD : ST_SW_RDA;
        end
      end
      ST_SW_RDA: begin
        wk_raddr  = mat_addr(ROW_W'(i_r), COL_W'(k_r));
        state_nxt = ST_SW_RDB;
      end
      ST_SW_RDB: begin
        tmp_nxt   = wk_rdata;
        wk_raddr  = mat_addr(ROW_W'(p_r), COL_W'(k_r));
        state_nxt = ST_SW_WA;
      end
      ST_SW_WA: begin
        wk_we     = 1'b1;
        wk_waddr  = mat_addr(ROW_W'(i_r), COL_W'(k_r));
        wk_wdata  = wk_rdata;
        state_nxt = ST_SW_WB;
      end
      ST_SW_WB: begin
        wk_we    = 1'b1;
        wk_waddr = mat_addr(ROW_W'(p_r), COL_W'(k_r));
        wk_wdata = tmp_r;
        if (k_last) begin
          k_nxt = '0;
          state_nxt = ST_RO_RDA;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = ST_SW_RDA;
        end
      end
      ST_RO_RDA: begin
        ro_raddr  = ROW_W'(i_r);
        state_nxt = ST_RO_RDB;
      end
      ST_RO_RDB: begin
        tmp_nxt   = DATA_W'(ro_rdata);
        ro_raddr  = ROW_W'(p_r);
        state_nxt = ST_RO_WA;
      end
      ST_RO_WA: begin
        ro_we     = 1'b1;
        ro_waddr  = ROW_W'(i_r);
        ro_wdata  = ro_rdata;
        state_nxt = ST_RO_WB;
      end
      ST_RO_WB: begin
        ro_we     = 1'b1;
        ro_waddr  = ROW_W'(p_r);
        ro_wdata  = tmp_r[ROW_W-1:0];
        state_nxt = ST_PIV_RD;
      end
      ST_PIV_RD: begin
        wk_raddr  = mat_addr(ROW_W'(i_r), COL_W'(i_r));
        state_nxt = ST_PIV_CHK;
      end
      ST_PIV_CHK: begin
        if (wk_rdata == '0) begin
          state_nxt = ST_ERR;
        end else begin
          piv_neg_nxt = wk_rdata[DATA_W-1];
          den_nxt     = abs32(wk_rdata);
          j_nxt       = '0;
          state_nxt   = ST_EL_J;
        end
      end
      ST_EL_J: begin
        if (j_r == i_r) begin
          if (j_last) begin
            step_done = 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          wk_raddr  = mat_addr(ROW_W'(j_r), COL_W'(i_r));
          state_nxt = ST_EF_CHK;
        end
      end
      ST_EF_CHK: begin
        f_nxt     = wk_rdata;
        k_nxt     = '0;
        state_nxt = ST_EK_RDA;
      end
      ST_EK_RDA: begin
        wk_raddr  = mat_addr(ROW_W'(i_r), COL_W'(k_r));
        state_nxt = ST_EK_RDB;
      end
      ST_EK_RDB: begin
        a_nxt     = wk_rdata;
        wk_raddr  = mat_addr(ROW_W'(j_r), COL_W'(k_r));
        state_nxt = ST_EK_MUL;
      end
      ST_EK_MUL: begin
        w_nxt     = wk_rdata;
        prod_nxt  = f_r * a_r;
        state_nxt = ST_EK_DST;
      end
      ST_EK_DST: begin
        qneg_nxt  = prod_r[PROD_W-1] ^ piv_neg_r;
        quo_nxt   = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = (prod_r == '0) ? ST_EK_WR : ST_EK_DIV;
      end
      ST_EK_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = DATA_W'(rem_sh - {1'b0, den_r});
          quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DATA_W-1:0];
          quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == '1) begin
          state_nxt = ST_EK_WR;
        end
      end
      ST_EK_WR: begin
        wk_we    = 1'b1;
        wk_waddr = mat_addr(ROW_W'(j_r), COL_W'(k_r));
        wk_wdata = (abs32(dsat) < DATA_W'(thr_r)) ? '0 : dsat;
        if (k_last) begin
          k_nxt = '0;
          if (j_last) begin
            step_done = 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
            state_nxt = ST_EL_J;
          end
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = ST_EK_RDA;
        end
      end
      ST_OZ_RD: begin
        wk_raddr  = mat_addr(ROW_W'(i_r), COL_W'(k_r));
        state_nxt = ST_OZ_CHK;
      end
      ST_OZ_CHK: begin
        state_nxt = ST_OZ_RD;
        if (is_nz(wk_rdata, thr_r)) begin
          state_nxt = ST_OR_RD;
        end else if (k_last) begin
          k_nxt = '0;
          if (i_last) begin
            state_nxt = ST_OUT_END;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_OR_RD: begin
        ro_raddr  = ROW_W'(i_r);
        state_nxt = ST_OR_CHK;
      end
      ST_OR_CHK: begin
        if (have_pend_r) begin
          ov_nxt = 1'b1;
          oi_nxt = 6'(pend_r);
          ol_nxt = 1'b0; oe_nxt = 1'b0; os_nxt = 1'b0;
        end
        pend_nxt      = ro_rdata;
        have_pend_nxt = 1'b1;
        k_nxt         = '0;
        if (i_last) begin
          state_nxt = ST_OUT_END;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = ST_OZ_RD;
        end
      end
      ST_OUT_END: begin
        ov_nxt = 1'b1;
        ol_nxt = 1'b1;
        os_nxt = 1'b0;
        oi_nxt = have_pend_r ? 6'(pend_r) : '0;
        oe_nxt = !have_pend_r;
        state_nxt = ST_LOAD;
      end
      ST_ERR: begin
        ov_nxt = 1'b1;
        oi_nxt = '0;
        ol_nxt = 1'b1; oe_nxt = 1'b0; os_nxt = 1'b1;
        state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase

    if (step_done) begin
      k_nxt = '0;
      if (i_last) begin
        i_nxt = '0;
        have_pend_nxt = 1'b0;
        state_nxt = ST_OZ_RD;
      end else begin
        i_nxt = i_r + 1'b1;
        p_nxt = i_r + 1'b1;
        state_nxt = ST_PZ_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      num_rows_r  <= RCNT_W'(MAX_ROWS);
      num_cols_r  <= CCNT_W'(MAX_COLS);
      thr_r       <= THR_RESET;
      lr_r        <= '0;
      lc_r        <= '0;
      i_r         <= '0;
      j_r         <= '0;
      p_r         <= '0;
      k_r         <= '0;
      v_r         <= '0;
      cnt_r       <= '0;
      dcnt_r      <= '0;
      have_pend_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_rows_r  <= num_rows_nxt;
      num_cols_r  <= num_cols_nxt;
      thr_r       <= thr_nxt;
      lr_r        <= lr_nxt;
      lc_r        <= lc_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      p_r         <= p_nxt;
      k_r         <= k_nxt;
      v_r         <= v_nxt;
      cnt_r       <= cnt_nxt;
      dcnt_r      <= dcnt_nxt;
      have_pend_r <= have_pend_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tmp_r     <= tmp_nxt;
    f_r       <= f_nxt;
    a_r       <= a_nxt;
    w_r       <= w_nxt;
    prod_r    <= prod_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    piv_neg_r <= piv_neg_nxt;
    qneg_r    <= qneg_nxt;
    pend_r    <= pend_nxt;
    oi_r      <= oi_nxt;
    ol_r      <= ol_nxt;
    oe_r      <= oe_nxt;
    os_r      <= os_nxt;
  end

  assign busy             = (state_r != ST_LOAD);
  assign out_valid        = ov_r;
  assign out_row_index    = oi_r;
  assign out_is_last      = ol_r;
  assign out_empty_set    = oe_r;
  assign out_sanity_error = os_r;

`ifndef ASSERT_OFF
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |-> !busy)
    else $error("final result while still busy");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_empty_set && out_sanity_error))
    else $error("empty and error flagged together");
  a_flag_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_empty_set || out_sanity_error) |-> out_is_last && out_row_index == '0)
    else $error("flagged result malformed");
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EK_DIV |-> den_r != '0)
    else $error("divider running on zero pivot");
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EK_DIV && dcnt_r == '1 |=> state_r == ST_EK_WR)
    else $error("divider did not hand over");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import ifr_pkg::*;

  localparam int SETTLE = 40;
  localparam int WDOG_LIMIT = 1_500_000;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    bit is_cfg;
    logic [CIDX_W-1:0] idx;
    logic [CFG_W-1:0] cdata;
    logic signed [31:0] elem;
    int gap;
  } pend_item_t;

  typedef struct {
    logic [5:0] row;
    logic last;
    logic empty;
    logic err;
  } row_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_element = '0;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [5:0] out_row_index;
  logic out_is_last;
  logic out_empty_set;
  logic out_sanity_error;

  independent_row_finder_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_element(in_element),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_row_index(out_row_index), .out_is_last(out_is_last),
    .out_empty_set(out_empty_set), .out_sanity_error(out_sanity_error)
  );

  pend_item_t pend_q[$];
  row_res_t rows_exp_q[$];

  // predictor state
  int p_nr = MAX_ROWS, p_nc = MAX_COLS, p_thr = 66, p_load = 0;
  int p_mat[MAX_ROWS][MAX_COLS];
  int p_wk[MAX_ROWS][MAX_COLS];

  // generator view of the configuration
  int g_nr = MAX_ROWS, g_nc = MAX_COLS, g_thr = 66, g_elems = 0;

  int n_elem = 0, n_res = 0, n_cfg = 0, n_err = 0, n_flag = 0;
  int idle_cnt = 0, wdog = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int clamp_dim(int v, int maxv);
    int m;
    m = v & 8'h7F;
    if (m == 0) return 1;
    if (m > maxv) return maxv;
    return m;
  endfunction

  function automatic longint mag(int x);
    return (x < 0) ? -longint'(x) : longint'(x);
  endfunction

  function automatic bit nz(int x);
    return mag(x) > longint'(p_thr);
  endfunction

  function automatic bit wk_row_zero(int r);
    for (int k = 0; k < p_nc; k++)
      if (nz(p_wk[r][k])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void push_row(int row, bit last, bit empty, bit err);
    row_res_t e;
    e.row = row[5:0];
    e.last = last;
    e.empty = empty;
    e.err = err;
    rows_exp_q = {rows_exp_q, e};
  endfunction

  function automatic void find_rows();
    int ck[MAX_COLS];
    int rk[MAX_ROWS];
    int co[MAX_COLS];
    int ro[MAX_ROWS];
    int v, j, p, t, n, first;
    longint f, piv, q, d;
    for (int k = 0; k < p_nc; k++) begin
      ck[k] = -1;
      for (int i = 0; i < p_nr; i++)
        if (nz(p_mat[i][k])) begin
          ck[k] = i;
          break;
        end
      co[k] = k;
    end
    for (int k = 1; k < p_nc; k++) begin
      v = co[k];
      j = k;
      while (j > 0 && ck[co[j-1]] < ck[v]) begin
        co[j] = co[j-1];
        j--;
      end
      co[j] = v;
    end
    for (int i = 0; i < p_nr; i++) begin
      rk[i] = -1;
      for (int k = 0; k < p_nc; k++)
        if (nz(p_mat[i][co[k]])) begin
          rk[i] = k;
          break;
        end
      ro[i] = i;
    end
    for (int i = 1; i < p_nr; i++) begin
      v = ro[i];
      j = i;
      while (j > 0 && rk[ro[j-1]] > rk[v]) begin
        ro[j] = ro[j-1];
        j--;
      end
      ro[j] = v;
    end
    for (int i = 0; i < p_nr; i++)
      for (int k = 0; k < p_nc; k++)
        p_wk[i][k] = p_mat[ro[i]][co[k]];

    for (int i = 0; i < p_nr; i++) begin
      p = i;
      while (p < p_nr) begin
        if (wk_row_zero(p)) p++;
        else if (i < p_nc) begin
          if (mag(p_wk[p][i]) < longint'(p_thr)) p++;
          else break;
        end else begin
          push_row(0, 1, 0, 1);
          return;
        end
      end
      if (p == p_nr) continue;
      if (p != i) begin
        for (int k = 0; k < MAX_COLS; k++) begin
          t = p_wk[i][k];
          p_wk[i][k] = p_wk[p][k];
          p_wk[p][k] = t;
        end
        t = ro[i];
        ro[i] = ro[p];
        ro[p] = t;
      end
      if (p_wk[i][i] == 0) begin
        push_row(0, 1, 0, 1);
        return;
      end
      for (int jj = 0; jj < p_nr; jj++) begin
        if (jj == i) continue;
        f = p_wk[jj][i];
        piv = p_wk[i][i];
        for (int k = 0; k < p_nc; k++) begin
          q = (f * longint'(p_wk[i][k])) / piv;
          d = longint'(p_wk[jj][k]) - q;
          if (d > 64'sd2147483647) d = 64'sd2147483647;
          if (d < -64'sd2147483648) d = -64'sd2147483648;
          if (((d < 0) ? -d : d) < longint'(p_thr)) d = 0;
          p_wk[jj][k] = int'(d);
        end
      end
    end

    n = 0;
    first = rows_exp_q.size();
    for (int i = 0; i < p_nr; i++)
      if (!wk_row_zero(i)) begin
        push_row(ro[i], 0, 0, 0);
        n++;
      end
    if (n == 0) push_row(0, 1, 1, 0);
    else rows_exp_q[first + n - 1].last = 1'b1;
  endfunction

  function automatic void load_element(int v);
    p_mat[p_load / p_nc][p_load % p_nc] = v;
    p_load++;
    if (p_load < p_nr * p_nc) return;
    p_load = 0;
    find_rows();
  endfunction

  function automatic void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_NUM_ROWS: begin
        p_nr = clamp_dim(val, MAX_ROWS);
        p_load = 0;
      end
      CFG_NUM_COLS: begin
        p_nc = clamp_dim(val, MAX_COLS);
        p_load = 0;
      end
      CFG_ZERO_THR: begin
        p_thr = val;
        p_load = 0;
      end
      default: ;
    endcase
  endfunction

  // stimulus builders
  task automatic add_cfg(logic [CIDX_W-1:0] idx, int val);
    pend_item_t it;
    it.is_cfg = 1'b1;
    it.idx = idx;
    it.cdata = val[CFG_W-1:0];
    it.elem = '0;
    it.gap = 0;
    pend_q = {pend_q, it};
    case (idx)
      CFG_NUM_ROWS: g_nr = clamp_dim(val, MAX_ROWS);
      CFG_NUM_COLS: g_nc = clamp_dim(val, MAX_COLS);
      CFG_ZERO_THR: g_thr = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic add_elem(int v, int gap);
    pend_item_t it;
    it.is_cfg = 1'b0;
    it.idx = '0;
    it.cdata = '0;
    it.elem = v;
    it.gap = gap;
    pend_q = {pend_q, it};
    g_elems++;
  endtask

  function automatic int rand_elem();
    int v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
      2: v = 0;
      3: v = (g_thr + int'($urandom_range(0, 2)) - 1) * ($urandom_range(1) ? 1 : -1);
      4: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = int'($urandom) >>> $urandom_range(31);
    endcase
    return v;
  endfunction

  // mode: 0 random, 1 dependent rows, 2 zeros
  task automatic add_matrix(int mode, int gap);
    int m[MAX_ROWS][MAX_COLS];
    int src, sc;
    for (int i = 0; i < g_nr; i++) begin
      src = (i > 0 && $urandom_range(1)) ? int'($urandom_range(0, i - 1)) : -1;
      sc = int'($urandom_range(0, 4)) - 2;
      for (int k = 0; k < g_nc; k++) begin
        if (mode == 2) m[i][k] = 0;
        else if (mode == 1 && src >= 0) m[i][k] = m[src][k] * sc;
        else m[i][k] = rand_elem();
      end
    end
    for (int i = 0; i < g_nr; i++)
      for (int k = 0; k < g_nc; k++)
        add_elem(m[i][k], gap);
  endtask

  // driver
  always @(posedge clk) begin
    logic nxt_start, nxt_we;
    nxt_start = 1'b0;
    nxt_we = 1'b0;
    if (rst_n) begin
      wdog++;
      if (start && !busy) begin
        load_element(in_element);
        n_elem++;
        wdog = 0;
      end
      if (out_valid) wdog = 0;
      if (rows_exp_q.size() == 0 && !busy && !start) idle_cnt++;
      else idle_cnt = 0;
      if (start && busy) nxt_start = 1'b1;
      else if (pend_q.size() > 0) begin
        if (pend_q[0].is_cfg) begin
          if (idle_cnt >= SETTLE) begin
            nxt_we = 1'b1;
            cfg_index <= pend_q[0].idx;
            cfg_data <= pend_q[0].cdata;
            write_reg(pend_q[0].idx, pend_q[0].cdata);
            pend_q.pop_front();
            n_cfg++;
            idle_cnt = 0;
            wdog = 0;
          end
        end else if (int'($urandom_range(99)) >= pend_q[0].gap) begin
          nxt_start = 1'b1;
          in_element <= pend_q[0].elem;
          pend_q.pop_front();
        end
      end
      if (wdog >= WDOG_LIMIT) begin
        $display("timeout: no item accepted for %0d cycles", WDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
  end

  // monitor
  always @(posedge clk) begin
    row_res_t e;
    if (rst_n && out_valid) begin
      n_res++;
      if (rows_exp_q.size() == 0) begin
        $error("unexpected result row_index=%0d", out_row_index);
        n_err++;
      end else begin
        e = rows_exp_q.pop_front();
        if (e.empty || e.err) n_flag++;
        if (out_row_index !== e.row) begin
          $error("row_index: expected %0d, got %0d", e.row, out_row_index);
          n_err++;
        end
        if (out_is_last !== e.last) begin
          $error("is_last: expected %0d, got %0d", e.last, out_is_last);
          n_err++;
        end
        if (out_empty_set !== e.empty) begin
          $error("empty_set: expected %0d, got %0d", e.empty, out_empty_set);
          n_err++;
        end
        if (out_sanity_error !== e.err) begin
          $error("sanity_error: expected %0d, got %0d", e.err, out_sanity_error);
          n_err++;
        end
      end
    end
  end

  initial begin
    int gap, thr;
    // directed
    add_cfg(CFG_NUM_ROWS, 2);
    add_cfg(CFG_NUM_COLS, 2);
    add_elem(32'h0001_0000, 6); add_elem(0, 6); add_elem(0, 6); add_elem(32'h0001_0000, 6);
    add_matrix(2, 6);
    add_elem(32'h7FFF_FFFF, 6); add_elem(32'h8000_0000, 6);
    add_elem(32'h8000_0000, 6); add_elem(32'h7FFF_FFFF, 6);
    // partial load discarded by a write, unknown index keeps the load
    add_elem(12345, 6);
    add_cfg(CFG_ZERO_THR, 66);
    add_elem(32'h0003_0000, 6);
    add_cfg(CFG_UNUSED, 16'hFFFF);
    add_elem(32'h0006_0000, 6); add_elem(32'h0001_0000, 6); add_elem(32'h0002_0000, 6);
    // zero rows reads as one row
    add_cfg(CFG_NUM_ROWS, 16'h0080);
    add_cfg(CFG_NUM_COLS, 3);
    add_elem(0, 6); add_elem(66, 6); add_elem(67, 6);
    // more rows than columns: no pivot column possible
    add_cfg(CFG_NUM_ROWS, 3);
    add_cfg(CFG_NUM_COLS, 2);
    add_matrix(0, 6);
    // zero threshold: zero pivot possible
    add_cfg(CFG_ZERO_THR, 0);
    add_cfg(CFG_NUM_ROWS, 2);
    add_elem(0, 6); add_elem(1, 6); add_elem(1, 6); add_elem(1, 6);
    // random part
    while (g_elems < 310) begin
      gap = (g_elems < 130) ? 6 : (g_elems < 230) ? 52 : 0;
      if (g_elems > 100 && g_elems < 110) begin
        add_cfg(CFG_NUM_ROWS, 1);
        add_cfg(CFG_NUM_COLS, 127);
        add_matrix(0, gap);
        add_cfg(CFG_NUM_ROWS, 64);
        add_cfg(CFG_NUM_COLS, 1);
        add_matrix(1, gap);
        add_cfg(CFG_NUM_ROWS, 4);
      end
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0: thr = 0;
          1: thr = 66;
          2: thr = 65535;
          default: thr = $urandom_range(0, 65535);
        endcase
        add_cfg(CFG_ZERO_THR, thr);
      end
      if ($urandom_range(1)) add_cfg(CFG_NUM_ROWS, $urandom_range(1, 5));
      if ($urandom_range(1)) add_cfg(CFG_NUM_COLS, $urandom_range(1, 5));
      case ($urandom_range(9))
        0: add_matrix(2, gap);
        1, 2, 3, 4: add_matrix(1, gap);
        default: add_matrix(0, gap);
      endcase
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pend_q.size() > 0 || start || busy || rows_exp_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d items loaded over %0d register writes; %0d results, %0d flagged",
             n_elem, n_cfg, n_res, n_flag);
    if (n_err == 0 && rows_exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, rows_exp_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
